// ----- sv/slir_pkg.sv -----
// ----------------------------------------------------------------------------
// slir_pkg
// shared constants, status codes and controller types for the sorted table
// ----------------------------------------------------------------------------
package slir_pkg;

	// table geometry
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	// port widths fixed by the request and result formats
	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	// request kinds
	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_BADINDEX = 3'd4
	} status_t;

	// controller states
	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_req;
		logic exec;
	} dp_cmd_t;

endpackage

// ----- sv/sorted_list_insert_remove_top.sv -----
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// bounded table of signed integers kept in ascending order
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries action, value and index.
//   action: clear, insert (after equal entries), remove first match, read.
//   output channel (out_valid/out_ready) carries status, count and
//   read_value, exactly one result per request.
// sequencing
//   a request is captured into the request register at its acceptance edge
//   and executed into the result register once the result slot is free; no
//   new request is accepted until the captured one has executed, set by the
//   capture/execute sequence of the controller. insert and remove shift all
//   entries in parallel through one comparator per entry.
// reset
//   arst_n empties the table; entry contents are not cleared, only the
//   entry count, so no clearing pass is needed.
// stalls
//   the result sits in an output register; a new request is captured while
//   it waits, and is executed in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top import slir_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ACTION_W-1:0]       action,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [INDEX_W-1:0]        index,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [STATUS_W-1:0]       status,
	output logic [COUNT_W-1:0]        count,
	output logic signed [VALUE_W-1:0] read_value
);

	dp_cmd_t cmd;

	// request sequencing
	slir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// table and result storage
	slir_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.value      (value),
		.index      (index),
		.status     (status),
		.count      (count),
		.read_value (read_value)
	);

endmodule

// ----- sv/slir_ctrl.sv -----
// ----------------------------------------------------------------------------
// slir_ctrl
// request sequencer: captures a request, runs it once the result slot is free
// ----------------------------------------------------------------------------
module slir_ctrl import slir_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic       out_valid_q;
	logic       slot_free;

	// result slot can take a new result this cycle
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (in_valid) state_d = CTL_EXEC;
			end
			CTL_EXEC: begin
				if (slot_free) state_d = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd.load_req = 1'b0;
		cmd.exec     = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			CTL_EXEC: begin
				cmd.exec = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// a result is never overwritten while it waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.exec)
		else $error("result overwritten while stalled");

	// each executed request raises the result flag
	a_exec_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("executed request without result");

	// a request is only captured when idle, execution only follows a capture
	a_exec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> state_q == CTL_EXEC)
		else $error("captured request not executed");

endmodule

// ----- sv/slir_dp.sv -----
// ----------------------------------------------------------------------------
// slir_dp
// sorted entry array with one comparator per entry and parallel shifting
// ----------------------------------------------------------------------------
module slir_dp import slir_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dp_cmd_t                    cmd,
	input  logic [ACTION_W-1:0]        action,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [INDEX_W-1:0]         index,
	output logic [STATUS_W-1:0]        status,
	output logic [COUNT_W-1:0]         count,
	output logic signed [VALUE_W-1:0]  read_value
);

	localparam int CMP_W = CNT_W + INDEX_W;

	// captured request
	action_t                   action_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [INDEX_W-1:0]        index_q;

	// table state
	logic signed [VALUE_W-1:0] entries_q [CAPACITY];
	logic [CNT_W-1:0]          count_q;

	// result register
	status_t                   status_q;
	logic [COUNT_W-1:0]        count_res_q;
	logic signed [VALUE_W-1:0] read_value_q;

	// per-entry compare results
	logic [CAPACITY-1:0] occ;
	logic [CAPACITY-1:0] le;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] seen;

	logic signed [VALUE_W-1:0] ins_arr [CAPACITY];
	logic signed [VALUE_W-1:0] rem_arr [CAPACITY];

	logic                      is_full;
	logic                      is_empty;
	logic                      found;
	logic                      idx_ok;

	status_t                   status_d;
	logic [CNT_W-1:0]          count_d;
	logic signed [VALUE_W-1:0] read_d;
	logic                      wr_ins;
	logic                      wr_rem;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= action_t'(action);
			value_q  <= value;
			index_q  <= index;
		end
	end

	// comparators, one per entry
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			occ[k] = CNT_W'(k) < count_q;
			le[k]  = occ[k] && (entries_q[k] <= value_q);
			eq[k]  = occ[k] && (entries_q[k] == value_q);
		end
	end

	// first-match mask for remove
	always_comb begin
		seen[0] = eq[0];
		for (int k = 1; k < CAPACITY; k++) begin
			seen[k] = seen[k-1] | eq[k];
		end
	end

	// shifted arrays for insert and remove
	always_comb begin
		for (int k = 0; k < CAPACITY; k++) begin
			if (le[k]) begin
				ins_arr[k] = entries_q[k];
			end else if (k == 0) begin
				ins_arr[k] = value_q;
			end else if (le[(k == 0) ? 0 : k-1]) begin
				ins_arr[k] = value_q;
			end else begin
				ins_arr[k] = entries_q[(k == 0) ? 0 : k-1];
			end
		end
		for (int k = 0; k < CAPACITY - 1; k++) begin
			rem_arr[k] = seen[k] ? entries_q[k+1] : entries_q[k];
		end
		rem_arr[CAPACITY-1] = entries_q[CAPACITY-1];
	end

	assign is_full  = count_q == CNT_W'(CAPACITY);
	assign is_empty = count_q == '0;
	assign found    = seen[CAPACITY-1];
	assign idx_ok   = CMP_W'(index_q) < CMP_W'(count_q);

	// request decode
	always_comb begin
		status_d = ST_OK;
		count_d  = count_q;
		read_d   = '0;
		wr_ins   = 1'b0;
		wr_rem   = 1'b0;
		unique case (action_q)
			ACT_CLEAR: begin
				count_d = '0;
			end
			ACT_INSERT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					wr_ins  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_NOTFOUND;
				end else begin
					wr_rem  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			ACT_READ: begin
				if (idx_ok) read_d = entries_q[IDX_W'(index_q)];
				else status_d = ST_BADINDEX;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// entry array update
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_ins) begin
			for (int k = 0; k < CAPACITY; k++) entries_q[k] <= ins_arr[k];
		end else if (cmd.exec && wr_rem) begin
			for (int k = 0; k < CAPACITY; k++) entries_q[k] <= rem_arr[k];
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= status_d;
			count_res_q  <= COUNT_W'(count_d);
			read_value_q <= read_d;
		end
	end

	assign status     = status_q;
	assign count      = count_res_q;
	assign read_value = read_value_q;

	// count stays within the table
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	// clear always empties the table
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && action_q == ACT_CLEAR |=> count_q == '0)
		else $error("clear left entries");

	// successful insert grows the count by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && wr_ins |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow count");

	// a failing request leaves the table size alone
	a_fail_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && status_d != ST_OK |=> $stable(count_q))
		else $error("failed request changed count");

endmodule

// ----- verif/sorted_table_checker.sv -----
// ----------------------------------------------------------------------------
// sorted_table_checker
// tracks the sorted table alongside the block, predicts the result of every
// accepted request and compares each returned result, in order, field by field
// ----------------------------------------------------------------------------
module sorted_table_checker import slir_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic [ACTION_W-1:0]       action,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [INDEX_W-1:0]        index,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [STATUS_W-1:0]       status,
	input  logic [COUNT_W-1:0]        count,
	input  logic signed [VALUE_W-1:0] read_value,
	output int                        pending,
	output int                        fails,
	output int                        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t                   st;
		logic [COUNT_W-1:0]        cnt;
		logic signed [VALUE_W-1:0] rd;
	} table_result_t;

	// shadow copy of the table contents and fill level
	logic signed [VALUE_W-1:0] shadow_tbl [CAPACITY];
	int unsigned               shadow_cnt = 0;
	table_result_t             awaited_results[$];

	// apply one request to the shadow table and return its result
	function automatic table_result_t apply_request(action_t act,
			logic signed [VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
		table_result_t r;
		int unsigned   pos;
		int unsigned   k;
		r.st = ST_OK;
		r.rd = '0;
		case (act)
		ACT_CLEAR: begin
			shadow_cnt = 0;
		end
		ACT_INSERT: begin
			if (shadow_cnt >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				// new value goes after any equal entries
				pos = 0;
				while (pos < shadow_cnt && shadow_tbl[pos] <= v)
					pos++;
				for (k = shadow_cnt; k > pos; k--)
					shadow_tbl[k] = shadow_tbl[k-1];
				shadow_tbl[pos] = v;
				shadow_cnt++;
			end
		end
		ACT_REMOVE: begin
			if (shadow_cnt == 0) begin
				r.st = ST_EMPTY;
			end else begin
				pos = 0;
				while (pos < shadow_cnt && shadow_tbl[pos] != v)
					pos++;
				if (pos >= shadow_cnt) begin
					r.st = ST_NOTFOUND;
				end else begin
					// close the gap left by the first match
					for (k = pos; k + 1 < shadow_cnt; k++)
						shadow_tbl[k] = shadow_tbl[k+1];
					shadow_cnt--;
				end
			end
		end
		default: begin
			if (idx < shadow_cnt)
				r.rd = shadow_tbl[idx];
			else
				r.st = ST_BADINDEX;
		end
		endcase
		r.cnt = COUNT_W'(shadow_cnt);
		return r;
	endfunction

	// compare returned results first, then queue the prediction for a new request
	always @(posedge clk or negedge arst_n) begin
		table_result_t want;
		if (!arst_n) begin
			shadow_cnt = 0;
			awaited_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result status=%0d count=%0d read_value=%0d",
							$time, status, count, read_value);
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (status !== want.st || count !== want.cnt || read_value !== want.rd) begin
						fails++;
						if (fails <= 10)
							$display("%0t: result mismatch: status %0d/%0d count %0d/%0d read_value %0d/%0d (expected/actual)",
								$time, want.st, status, want.cnt, count, want.rd, read_value);
					end
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_request(action_t'(action), value, index));
		end
		pending = awaited_results.size();
	end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives clear, insert, remove and read requests into the sorted table with
// random gaps on both channels; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import slir_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 725;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {
		PH_GROW,
		PH_SHRINK,
		PH_MIX
	} phase_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [ACTION_W-1:0]       action;
	logic signed [VALUE_W-1:0] value;
	logic [INDEX_W-1:0]        index;
	logic                      out_valid;
	logic                      out_ready;
	logic [STATUS_W-1:0]       status;
	logic [COUNT_W-1:0]        count;
	logic signed [VALUE_W-1:0] read_value;

	int pending;
	int fails;
	int checked;

	int                        sent_by_kind [4];
	logic signed [VALUE_W-1:0] inserted_vals[$];
	bit                        steady_phase;
	int                        idle_cycles = 0;

	sorted_list_insert_remove_top DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.read_value (read_value)
	);

	sorted_table_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.index      (index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.count      (count),
		.read_value (read_value),
		.pending    (pending),
		.fails      (fails),
		.checked    (checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// small values give ties and matches, extremes hit the sign boundary
	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		int near_zero;
		r = $urandom_range(0, 99);
		if (r < 25) begin
			near_zero = $urandom_range(0, 8);
			return near_zero - 4;
		end
		if (r < 35) begin
			case ($urandom_range(0, 4))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return -1;
			3: return 0;
			default: return 1;
			endcase
		end
		return $urandom;
	endfunction

	// mostly short gaps, a few long ones, none in a steady phase
	function automatic int pick_gap();
		int r;
		if (steady_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	// present one request at a falling edge and hold it until accepted
	task automatic send_request(action_t act, logic signed [VALUE_W-1:0] v,
			logic [INDEX_W-1:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		value    <= v;
		index    <= idx;
		sent_by_kind[act]++;
		if (act == ACT_INSERT) begin
			inserted_vals.push_back(v);
			if (inserted_vals.size() > 40)
				void'(inserted_vals.pop_front());
		end
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off new requests until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// result side: ready stretches, short stalls and occasional long ones
	initial begin
		int r;
		int n;
		out_ready = 1'b0;
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			n = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (n) @(negedge clk);
			if (r >= 15) begin
				n = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_list_insert_remove_top regression: fail");
			$finish;
		end
	end

	// request stimulus and verdict
	initial begin
		int                        n_random;
		int                        ph_len;
		int                        r;
		phase_t                    ph;
		action_t                   act;
		logic signed [VALUE_W-1:0] v;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		action       = ACT_CLEAR;
		value        = '0;
		index        = '0;
		steady_phase = 1'b0;
		n_random     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table: read and remove both refused
		send_request(ACT_READ, 0, 4'd15);
		send_request(ACT_REMOVE, 5, 4'd0);
		// extremes and a duplicate
		send_request(ACT_INSERT, VAL_MAX, 4'd0);
		send_request(ACT_INSERT, VAL_MIN, 4'd0);
		send_request(ACT_INSERT, 0, 4'd0);
		send_request(ACT_INSERT, 0, 4'd0);
		send_request(ACT_READ, 0, 4'd0);
		send_request(ACT_READ, 0, 4'd3);
		// read just past the end, remove with no match, then a match
		send_request(ACT_READ, 0, 4'd4);
		send_request(ACT_REMOVE, 7, 4'd0);
		send_request(ACT_REMOVE, 0, 4'd0);
		// fill to capacity, then insert into a full table
		for (int k = 0; k < 13; k++)
			send_request(ACT_INSERT, pick_value(), 4'(k));
		send_request(ACT_INSERT, -1, 4'd0);
		send_request(ACT_READ, 0, 4'd15);
		// clear hides every entry
		send_request(ACT_CLEAR, -1, 4'd15);
		send_request(ACT_READ, 0, 4'd0);
		drain_results();

		// random phases that grow, shrink or churn the table
		while (n_random < RANDOM_ITEMS) begin
			ph           = phase_t'($urandom_range(0, 2));
			ph_len       = $urandom_range(8, 40);
			steady_phase = ($urandom_range(0, 3) == 0);
			repeat (ph_len) begin
				r = $urandom_range(0, 99);
				case (ph)
				PH_GROW:   act = (r < 65) ? ACT_INSERT : (r < 80) ? ACT_READ :
				                 (r < 97) ? ACT_REMOVE : ACT_CLEAR;
				PH_SHRINK: act = (r < 20) ? ACT_INSERT : (r < 45) ? ACT_READ :
				                 (r < 98) ? ACT_REMOVE : ACT_CLEAR;
				default:   act = (r < 40) ? ACT_INSERT : (r < 65) ? ACT_READ :
				                 (r < 95) ? ACT_REMOVE : ACT_CLEAR;
				endcase
				// removes mostly target a value inserted earlier
				if (act == ACT_REMOVE && inserted_vals.size() > 0 && $urandom_range(0, 9) < 7)
					v = inserted_vals[$urandom_range(0, inserted_vals.size() - 1)];
				else if (act == ACT_CLEAR || act == ACT_READ)
					v = $urandom;
				else
					v = pick_value();
				send_request(act, v, 4'($urandom_range(0, 15)));
				n_random++;
			end
			if ($urandom_range(0, 5) == 0)
				drain_results();
		end

		drain_results();
		repeat (8) @(negedge clk);
		$display("requests sent: %0d clear, %0d insert, %0d remove, %0d read",
			sent_by_kind[ACT_CLEAR], sent_by_kind[ACT_INSERT],
			sent_by_kind[ACT_REMOVE], sent_by_kind[ACT_READ]);
		$display("results compared: %0d, mismatches: %0d", checked, fails);
		if (fails == 0)
			$display("sorted_list_insert_remove_top regression: pass");
		else
			$display("sorted_list_insert_remove_top regression: fail");
		$finish;
	end

endmodule
